// ===== design/eiprlp_pkg.sv =====
package eiprlp_pkg;

   // result kinds
   localparam logic [3:0] KIND_CHAIN      = 4'd0;
   localparam logic [3:0] KIND_NONCE      = 4'd1;
   localparam logic [3:0] KIND_TIP_CAP    = 4'd2;
   localparam logic [3:0] KIND_FEE_CAP    = 4'd3;
   localparam logic [3:0] KIND_GAS        = 4'd4;
   localparam logic [3:0] KIND_TO_ABSENT  = 4'd5;
   localparam logic [3:0] KIND_TO_BYTE    = 4'd6;
   localparam logic [3:0] KIND_VALUE      = 4'd7;
   localparam logic [3:0] KIND_DATA_LEN   = 4'd8;
   localparam logic [3:0] KIND_DATA_BYTE  = 4'd9;
   localparam logic [3:0] KIND_STATUS     = 4'd10;

   // status codes
   localparam logic [3:0] ST_OK           = 4'd0;
   localparam logic [3:0] ST_BAD_TYPE     = 4'd1;
   localparam logic [3:0] ST_TRUNCATED    = 4'd2;
   localparam logic [3:0] ST_NOT_LIST     = 4'd3;
   localparam logic [3:0] ST_ITEM_FIT     = 4'd4;
   localparam logic [3:0] ST_FIELD_LIST   = 4'd5;
   localparam logic [3:0] ST_INT_LONG     = 4'd6;
   localparam logic [3:0] ST_TO_LEN       = 4'd7;

   // field numbers inside the outer list
   localparam logic [3:0] FIELD_VALUE     = 4'd6;
   localparam logic [3:0] FIELD_TO        = 4'd5;
   localparam logic [3:0] FIELD_DATA      = 4'd7;
   localparam logic [3:0] FIELD_ACCESS    = 4'd8;
   localparam logic [3:0] FIELD_PAST_END  = 4'd9;

   // RLP header byte bounds
   localparam logic [7:0] TX_TYPE_BYTE    = 8'h02;
   localparam logic [7:0] SINGLE_MAX      = 8'h7f;
   localparam logic [7:0] STR_SHORT_BASE  = 8'h80;
   localparam logic [7:0] STR_SHORT_MAX   = 8'hb7;
   localparam logic [7:0] LIST_SHORT_BASE = 8'hc0;
   localparam logic [7:0] LIST_SHORT_MAX  = 8'hf7;
   localparam logic [7:0] LIST_LONG_MIN   = 8'hf8;
   localparam logic [7:0] TO_BYTES        = 8'd20;
   localparam logic [7:0] INT_MAX_BYTES   = 8'd8;

   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      logic [3:0]  kind;
      logic [63:0] value;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

// ===== design/eiprlp_step.sv =====
module eiprlp_step #(
   parameter int LENGTH_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output eiprlp_pkg::push_type push
);

   localparam logic [63:0] LenMax = {64{1'b1}} >> (64 - LENGTH_WIDTH);

   typedef enum logic [3:0] {
      PH_TYPE, PH_OHDR, PH_OLEN, PH_OSTR, PH_IHDR, PH_ILEN, PH_IPAY, PH_DRAIN, PH_DONE
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [3:0]              lbl_ff, lbl_in;
   logic [LENGTH_WIDTH-1:0] outer_ff, outer_in;
   logic [LENGTH_WIDTH-1:0] item_ff, item_in;
   logic [3:0]              field_ff, field_in;
   logic [63:0]             acc_ff, acc_in;
   logic                    is_list_ff, is_list_in;
   logic [3:0]              err_ff, err_in;

   logic [1:0]              n;
   eiprlp_pkg::result_type  r0, r1, res;
   logic                    ob_go, ob_list;
   logic [63:0]             ob_len;
   logic                    ready_go, rlist, lit, pay;
   logic [63:0]             rlen;
   logic [63:0]             hdr_len;
   logic [3:0]              int_kind;

   function automatic eiprlp_pkg::result_type mk(input logic [3:0] kind, input logic [63:0] v);
      eiprlp_pkg::result_type r;
      r.kind        = kind;
      r.value       = v;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   always_comb begin
      phase_in   = phase_ff;
      lbl_in     = lbl_ff;
      outer_in   = outer_ff;
      item_in    = item_ff;
      field_in   = field_ff;
      acc_in     = acc_ff;
      is_list_in = is_list_ff;
      err_in     = err_ff;
      n          = 2'd0;
      r0         = '0;
      r1         = '0;
      res        = '0;
      ob_go      = 1'b0;
      ob_list    = 1'b0;
      ob_len     = '0;
      ready_go   = 1'b0;
      rlist      = 1'b0;
      rlen       = '0;
      lit        = 1'b0;
      pay        = 1'b0;
      hdr_len    = '0;
      int_kind   = (field_ff == eiprlp_pkg::FIELD_VALUE) ? eiprlp_pkg::KIND_VALUE : field_ff;

      case (phase_ff)
         PH_TYPE: begin
            if (data_byte != eiprlp_pkg::TX_TYPE_BYTE) begin
               err_in   = eiprlp_pkg::ST_BAD_TYPE;
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_OHDR;
            end
         end
         PH_OHDR: begin
            if (data_byte <= eiprlp_pkg::SINGLE_MAX) begin
               err_in   = eiprlp_pkg::ST_NOT_LIST;
               phase_in = PH_DONE;
            end else if (data_byte <= eiprlp_pkg::STR_SHORT_MAX) begin
               ob_go  = 1'b1;
               ob_len = 64'(8'(data_byte - eiprlp_pkg::STR_SHORT_BASE));
            end else if (data_byte >= eiprlp_pkg::LIST_SHORT_BASE &&
                         data_byte <= eiprlp_pkg::LIST_SHORT_MAX) begin
               ob_go   = 1'b1;
               ob_list = 1'b1;
               ob_len  = 64'(8'(data_byte - eiprlp_pkg::LIST_SHORT_BASE));
            end else begin
               is_list_in = data_byte >= eiprlp_pkg::LIST_LONG_MIN;
               lbl_in     = 4'(data_byte - (is_list_in ? eiprlp_pkg::LIST_SHORT_MAX
                                                       : eiprlp_pkg::STR_SHORT_MAX));
               acc_in     = '0;
               phase_in   = PH_OLEN;
            end
         end
         PH_OLEN: begin
            acc_in = {acc_ff[55:0], data_byte};
            if (lbl_ff != 4'd0) lbl_in = lbl_ff - 4'd1;
            if (lbl_in == 4'd0) begin
               ob_go   = 1'b1;
               ob_list = is_list_ff;
               ob_len  = acc_in;
            end
         end
         PH_OSTR: begin
            if (outer_ff != '0) outer_in = outer_ff - 1'b1;
            if (outer_in == '0) begin
               err_in   = eiprlp_pkg::ST_NOT_LIST;
               phase_in = PH_DONE;
            end
         end
         PH_IHDR, PH_ILEN, PH_IPAY, PH_DRAIN: begin
            if (outer_ff != '0) outer_in = outer_ff - 1'b1;
            if (phase_ff == PH_IHDR) begin
               if (data_byte <= eiprlp_pkg::SINGLE_MAX) begin
                  ready_go = 1'b1;
                  rlen     = 64'd1;
                  lit      = 1'b1;
               end else if (data_byte <= eiprlp_pkg::STR_SHORT_MAX ||
                            (data_byte >= eiprlp_pkg::LIST_SHORT_BASE &&
                             data_byte <= eiprlp_pkg::LIST_SHORT_MAX)) begin
                  rlist   = data_byte >= eiprlp_pkg::LIST_SHORT_BASE;
                  hdr_len = 64'(8'(data_byte - (rlist ? eiprlp_pkg::LIST_SHORT_BASE
                                                      : eiprlp_pkg::STR_SHORT_BASE)));
                  if (hdr_len > 64'(outer_in)) begin
                     if (err_in == eiprlp_pkg::ST_OK) err_in = eiprlp_pkg::ST_ITEM_FIT;
                     phase_in = PH_DRAIN;
                  end else begin
                     ready_go = 1'b1;
                     rlen     = hdr_len;
                  end
               end else begin
                  is_list_in = data_byte >= eiprlp_pkg::LIST_LONG_MIN;
                  lbl_in     = 4'(data_byte - (is_list_in ? eiprlp_pkg::LIST_SHORT_MAX
                                                          : eiprlp_pkg::STR_SHORT_MAX));
                  if (64'(lbl_in) > 64'(outer_in)) begin
                     if (err_in == eiprlp_pkg::ST_OK) err_in = eiprlp_pkg::ST_ITEM_FIT;
                     phase_in = PH_DRAIN;
                  end else begin
                     acc_in   = '0;
                     phase_in = PH_ILEN;
                  end
               end
            end else if (phase_ff == PH_ILEN) begin
               acc_in = {acc_ff[55:0], data_byte};
               if (lbl_ff != 4'd0) lbl_in = lbl_ff - 4'd1;
               if (lbl_in == 4'd0) begin
                  if (acc_in > 64'(outer_in)) begin
                     if (err_in == eiprlp_pkg::ST_OK) err_in = eiprlp_pkg::ST_ITEM_FIT;
                     phase_in = PH_DRAIN;
                  end else begin
                     ready_go = 1'b1;
                     rlist    = is_list_ff;
                     rlen     = acc_in;
                  end
               end
            end else if (phase_ff == PH_IPAY) begin
               pay = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // outer item header complete
      if (ob_go) begin
         outer_in = (ob_len > LenMax) ? LENGTH_WIDTH'(LenMax) : ob_len[LENGTH_WIDTH-1:0];
         if (ob_list) begin
            field_in = '0;
            phase_in = PH_IHDR;
         end else if (outer_in == '0) begin
            err_in   = eiprlp_pkg::ST_NOT_LIST;
            phase_in = PH_DONE;
         end else begin
            phase_in = PH_OSTR;
         end
      end

      // inner item header complete
      if (ready_go) begin
         if (field_in >= eiprlp_pkg::FIELD_ACCESS) begin
            field_in = eiprlp_pkg::FIELD_PAST_END;
            phase_in = PH_DRAIN;
         end else if (rlist) begin
            if (err_in == eiprlp_pkg::ST_OK) err_in = eiprlp_pkg::ST_FIELD_LIST;
            phase_in = PH_DRAIN;
         end else if (field_in == eiprlp_pkg::FIELD_TO) begin
            if (rlen == 64'd0) begin
               r0       = mk(eiprlp_pkg::KIND_TO_ABSENT, 64'd0);
               n        = 2'd1;
               field_in = field_in + 4'd1;
               phase_in = PH_IHDR;
            end else if (rlen == 64'(eiprlp_pkg::TO_BYTES)) begin
               item_in  = LENGTH_WIDTH'(eiprlp_pkg::TO_BYTES);
               phase_in = PH_IPAY;
            end else begin
               if (err_in == eiprlp_pkg::ST_OK) err_in = eiprlp_pkg::ST_TO_LEN;
               phase_in = PH_DRAIN;
            end
         end else if (field_in == eiprlp_pkg::FIELD_DATA) begin
            r0 = mk(eiprlp_pkg::KIND_DATA_LEN, rlen);
            n  = 2'd1;
            if (rlen == 64'd0) begin
               field_in = field_in + 4'd1;
               phase_in = PH_IHDR;
            end else begin
               item_in  = rlen[LENGTH_WIDTH-1:0];
               phase_in = PH_IPAY;
            end
         end else if (rlen > 64'(eiprlp_pkg::INT_MAX_BYTES)) begin
            if (err_in == eiprlp_pkg::ST_OK) err_in = eiprlp_pkg::ST_INT_LONG;
            phase_in = PH_DRAIN;
         end else begin
            acc_in = '0;
            if (rlen == 64'd0) begin
               r0       = mk(int_kind, 64'd0);
               n        = 2'd1;
               field_in = field_in + 4'd1;
               phase_in = PH_IHDR;
            end else begin
               item_in  = rlen[LENGTH_WIDTH-1:0];
               phase_in = PH_IPAY;
            end
         end
      end

      // a single-byte item is its own payload
      if (lit && phase_in == PH_IPAY) pay = 1'b1;

      if (pay) begin
         if (item_in != '0) item_in = item_in - 1'b1;
         if (field_in == eiprlp_pkg::FIELD_TO) begin
            res = mk(eiprlp_pkg::KIND_TO_BYTE, 64'(data_byte));
         end else if (field_in == eiprlp_pkg::FIELD_DATA) begin
            res = mk(eiprlp_pkg::KIND_DATA_BYTE, 64'(data_byte));
         end else begin
            acc_in = {acc_in[55:0], data_byte};
         end
         if (item_in == '0 && field_in != eiprlp_pkg::FIELD_TO &&
             field_in != eiprlp_pkg::FIELD_DATA) begin
            res = mk(int_kind, acc_in);
         end
         if (field_in == eiprlp_pkg::FIELD_TO || field_in == eiprlp_pkg::FIELD_DATA ||
             item_in == '0) begin
            if (n == 2'd0) r0 = res;
            else r1 = res;
            n = n + 2'd1;
         end
         if (item_in == '0) begin
            field_in = field_in + 4'd1;
            phase_in = PH_IHDR;
         end
      end

      // outer list used up: close the parse
      if (phase_in >= PH_IHDR && phase_in <= PH_DRAIN && outer_in == '0) begin
         if (phase_in != PH_DRAIN && err_in == eiprlp_pkg::ST_OK)
            err_in = eiprlp_pkg::ST_ITEM_FIT;
         phase_in = PH_DONE;
      end

      if (last_byte) begin
         // only the status leaves on the final byte; start over afterwards
         r0 = mk(eiprlp_pkg::KIND_STATUS, (phase_in == PH_DONE) ? 64'(err_in)
                                                               : 64'(eiprlp_pkg::ST_TRUNCATED));
         n          = 2'd1;
         phase_in   = PH_TYPE;
         lbl_in     = '0;
         outer_in   = '0;
         item_in    = '0;
         field_in   = '0;
         acc_in     = '0;
         is_list_in = 1'b0;
         err_in     = eiprlp_pkg::ST_OK;
      end

      r0.last_of_run = (n == 2'd1);
      r1.last_of_run = 1'b1;
      push.count     = advance ? n : 2'd0;
      push.r0        = r0;
      push.r1        = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TYPE;
         lbl_ff     <= '0;
         outer_ff   <= '0;
         item_ff    <= '0;
         field_ff   <= '0;
         acc_ff     <= '0;
         is_list_ff <= 1'b0;
         err_ff     <= eiprlp_pkg::ST_OK;
      end else if (advance) begin
         phase_ff   <= phase_in;
         lbl_ff     <= lbl_in;
         outer_ff   <= outer_in;
         item_ff    <= item_in;
         field_ff   <= field_in;
         acc_ff     <= acc_in;
         is_list_ff <= is_list_in;
         err_ff     <= err_in;
      end
   end

endmodule

// ===== design/eiprlp_rsp_fifo.sv =====
module eiprlp_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  eiprlp_pkg::push_type   push,
   input  logic                   pop,
   output logic                   has_room,
   output logic                   out_valid,
   output eiprlp_pkg::result_type out_head
);

   localparam int PtrWidth = $clog2(eiprlp_pkg::RSP_DEPTH);

   eiprlp_pkg::result_type entry_ff [eiprlp_pkg::RSP_DEPTH];
   logic [PtrWidth-1:0]    wr_ff, wr_in, wr_next;
   logic [PtrWidth-1:0]    rd_ff, rd_in;
   logic [PtrWidth:0]      count_ff, count_in;

   // room for two results regardless of what drains this cycle
   assign has_room  = count_ff <= (PtrWidth + 1)'(eiprlp_pkg::RSP_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_head  = entry_ff[rd_ff];
   assign wr_next   = wr_ff + 1'b1;
   assign wr_in     = wr_ff + PtrWidth'(push.count);
   assign rd_in     = pop ? rd_ff + 1'b1 : rd_ff;
   assign count_in  = count_ff + (PtrWidth + 1)'(push.count) - (PtrWidth + 1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push.count != 2'd0) entry_ff[wr_ff] <= push.r0;
      if (push.count == 2'd2) entry_ff[wr_next] <= push.r1;
   end

endmodule

// ===== design/eip1559_rlp_tx_parser_top.sv =====
// Byte-serial parser for typed EIP-1559 transactions. Feed the raw buffer one
// byte per req_ transfer and mark its final byte with req_last_byte. The block
// checks the 0x02 type byte and the outer RLP list header, then emits chain id,
// nonce, tip cap, fee cap, gas limit and value as integers of up to 8 bytes,
// the 20 recipient bytes or an absent marker, the data length followed by each
// data byte, and skips the access list. The final byte yields one status
// result (kind 10): 0 ok, 1 bad type byte, 2 buffer ends inside the outer item,
// 3 outer item not a list, 4 missing or overrunning list item, 5 a field is a
// list, 6 integer over 8 bytes, 7 recipient length not 0 or 20. A nonzero
// status voids every result since the previous status; the next byte starts a
// new transaction. Rate: one byte is taken per cycle while the result queue
// has room for two results. A byte yields zero, one or two results and the
// rsp_ side drains one per cycle while rsp_ready is high. A data item written
// as a lone byte below 0x80 yields its length and its byte together. A req_
// byte is held in a register; its results enter the queue when it advances.
module eip1559_rlp_tx_parser_top #(
   parameter int LENGTH_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_kind,
   output logic [63:0] rsp_value,
   output logic        rsp_last_of_run
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;
   logic                   advance;
   logic                   has_room;
   eiprlp_pkg::push_type   push;
   eiprlp_pkg::result_type head;

   // advance the held byte when the queue can take whatever it produces
   assign advance     = in_valid_ff && has_room;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_valid ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   eiprlp_step #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
   ) u_step (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .data_byte(in_byte_ff),
      .last_byte(in_last_ff),
      .push     (push)
   );

   eiprlp_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (rsp_valid && rsp_ready),
      .has_room (has_room),
      .out_valid(rsp_valid),
      .out_head (head)
   );

   assign rsp_kind        = head.kind;
   assign rsp_value       = head.value;
   assign rsp_last_of_run = head.last_of_run;

endmodule
